// ===== hdl/planar_odometry_integrator_top_assert.svh =====
// Assertion macros used by the odometry integrator top module.
`ifndef PLANAR_ODOMETRY_INTEGRATOR_TOP_ASSERT_SVH
`define PLANAR_ODOMETRY_INTEGRATOR_TOP_ASSERT_SVH

// same-cycle implication, reset-qualified
`define POI_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, reset-qualified
`define POI_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== hdl/poi_pkg.sv =====
// Package: types, constants and helpers of the planar odometry integrator.
`timescale 1ns / 1ps
package poi_pkg;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int POS_BITS_DEF     = 48;
  localparam int MUL_CNT_W        = 5;
  localparam int MUL_B_W          = 24;
  localparam int CW               = 34;

  localparam logic [23:0] GAP_RESET  = 24'd1000000;
  localparam logic [23:0] YAW_SCALE  = 24'd11468322;
  localparam logic signed [CW-1:0] CORDIC_X0 = 34'sd652032874;

  typedef struct packed {
    logic               mode;
    logic [47:0]        stamp_us;
    logic signed [15:0] lin_vel;
    logic signed [15:0] ang_vel;
  } poi_in_t;

  typedef struct packed {
    logic signed [47:0] x_nm;
    logic signed [47:0] y_nm;
    logic [31:0]        yaw;
    logic signed [15:0] quat_z;
    logic signed [15:0] quat_w;
    logic signed [15:0] speed_out;
    logic signed [15:0] turn_rate_out;
    logic [47:0]        stamp_out;
  } poi_out_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_COR1, ST_MUL1, ST_MUL2, ST_MUL3, ST_MUL4, ST_COR2, ST_OUT
  } poi_state_t;

  function automatic logic signed [CW-1:0] atan_lut(input logic [4:0] i);
    logic signed [CW-1:0] r;
    unique case (i)
      5'd0:  r = 34'sd536870912;
      5'd1:  r = 34'sd316933406;
      5'd2:  r = 34'sd167458907;
      5'd3:  r = 34'sd85004756;
      5'd4:  r = 34'sd42667331;
      5'd5:  r = 34'sd21354465;
      5'd6:  r = 34'sd10679838;
      5'd7:  r = 34'sd5340245;
      5'd8:  r = 34'sd2670163;
      5'd9:  r = 34'sd1335087;
      5'd10: r = 34'sd667544;
      5'd11: r = 34'sd333772;
      5'd12: r = 34'sd166886;
      5'd13: r = 34'sd83443;
      5'd14: r = 34'sd41722;
      5'd15: r = 34'sd20861;
      5'd16: r = 34'sd10430;
      5'd17: r = 34'sd5215;
      5'd18: r = 34'sd2608;
      5'd19: r = 34'sd1304;
      5'd20: r = 34'sd652;
      5'd21: r = 34'sd326;
      5'd22: r = 34'sd163;
      5'd23: r = 34'sd81;
      5'd24: r = 34'sd41;
      5'd25: r = 34'sd20;
      5'd26: r = 34'sd10;
      5'd27: r = 34'sd5;
      5'd28: r = 34'sd3;
      5'd29: r = 34'sd1;
      default: r = '0;
    endcase
    return r;
  endfunction

  // round half up, drop 15 fraction bits
  function automatic logic signed [63:0] rnd15(input logic signed [63:0] a);
    logic signed [63:0] t;
    t = a + 64'sd16384;
    return t >>> 15;
  endfunction

  function automatic logic signed [15:0] q15(input logic signed [CW-1:0] a);
    logic signed [CW-1:0] t;
    logic signed [CW-1:0] r;
    t = a + 34'sd16384;
    r = t >>> 15;
    if (r > 34'sd32767) return 16'sd32767;
    if (r < -34'sd32768) return -16'sd32768;
    return 16'(r);
  endfunction

endpackage

// ===== hdl/planar_odometry_integrator_top.sv =====
// Top level: dead-reckoning sequencer, pose state and output register.
// Each accepted sample runs a CORDIC pass, the serial multiplier passes and a second CORDIC pass;
// in_stall stays high until the result is loaded, so no new sample is taken before then.
// Clear words and dropped samples give no result.
// A finished result waits in the output register while the next word is taken.
// Synchronous active-low reset zeroes the pose and last stamp and sets the gap limit gap_r to 1000000.
`timescale 1ns / 1ps
module planar_odometry_integrator_top #(
  parameter int CORDIC_STEPS = poi_pkg::CORDIC_STEPS_DEF,
  parameter int POS_BITS     = poi_pkg::POS_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  poi_pkg::poi_in_t in_word,
  output logic             out_valid,
  input  logic             out_stall,
  output poi_pkg::poi_out_t out_word,
  input  logic             cfg_we,
  input  logic [23:0]      cfg_wdata
);

  poi_pkg::poi_state_t state_r, state_nxt;

  logic [23:0]                gap_r, dt_r;
  logic [47:0]                last_r, stamp_r;
  logic signed [15:0]         v_r, w_r;
  logic signed [POS_BITS-1:0] posx_r, posy_r, posx_nxt, posy_nxt;
  logic [31:0]                head_r, head_nxt;
  poi_pkg::poi_out_t          out_r;
  logic                       out_valid_r;

  logic        acc, take, clr, pos_upd, head_upd, out_load;
  logic [47:0] diff;
  logic        ok;

  logic                            cor_start, cor_done;
  logic [31:0]                     cor_ang;
  logic signed [poi_pkg::CW-1:0]   cor_c, cor_s;
  logic                            mx_start, my_start, mx_done, my_done, m_sgn;
  logic signed [63:0]              mx_a, my_a, mx_p, my_p, hsum;
  logic [poi_pkg::MUL_B_W-1:0]     mx_b, my_b;
  logic [poi_pkg::MUL_CNT_W-1:0]   m_n;
  logic signed [65:0]              hi66, lo66, sx, sy;

  poi_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
    .clk(clk), .rst_n(rst_n), .start(cor_start), .ang(cor_ang),
    .cos_o(cor_c), .sin_o(cor_s), .done(cor_done)
  );

  poi_smul u_mulx (
    .clk(clk), .rst_n(rst_n), .start(mx_start), .a(mx_a), .b(mx_b),
    .nbits(m_n), .b_signed(m_sgn), .prod(mx_p), .done(mx_done)
  );

  poi_smul u_muly (
    .clk(clk), .rst_n(rst_n), .start(my_start), .a(my_a), .b(my_b),
    .nbits(m_n), .b_signed(m_sgn), .prod(my_p), .done(my_done)
  );

  assign in_stall = (state_r != poi_pkg::ST_IDLE);
  assign acc      = in_valid && !in_stall;

  always_comb begin
    diff = in_word.stamp_us - last_r;
    ok   = (diff != '0) && !diff[47] && (diff <= {24'd0, gap_r});
    hi66 = (66'sd1 <<< (POS_BITS - 1)) - 66'sd1;
    lo66 = -hi66 - 66'sd1;
    sx   = 66'(posx_r) + 66'(poi_pkg::rnd15(mx_p));
    sy   = 66'(posy_r) + 66'(poi_pkg::rnd15(my_p));
    posx_nxt = (sx > hi66) ? POS_BITS'(hi66) : (sx < lo66) ? POS_BITS'(lo66) : POS_BITS'(sx);
    posy_nxt = (sy > hi66) ? POS_BITS'(hi66) : (sy < lo66) ? POS_BITS'(lo66) : POS_BITS'(sy);
    hsum     = mx_p + (64'sd1 <<< 23);
    head_nxt = head_r + hsum[55:24];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= poi_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    take      = 1'b0;
    clr       = 1'b0;
    pos_upd   = 1'b0;
    head_upd  = 1'b0;
    out_load  = 1'b0;
    cor_start = 1'b0;
    cor_ang   = head_r;
    mx_start  = 1'b0;
    my_start  = 1'b0;
    mx_a      = 64'(cor_c);
    my_a      = 64'(cor_s);
    mx_b      = poi_pkg::MUL_B_W'($unsigned(v_r));
    my_b      = poi_pkg::MUL_B_W'($unsigned(v_r));
    m_n       = poi_pkg::MUL_CNT_W'(16);
    m_sgn     = 1'b1;
    unique case (state_r)
      poi_pkg::ST_IDLE: begin
        if (acc) begin
          if (in_word.mode) begin
            clr = 1'b1;
          end else begin
            take = 1'b1;
            if (ok) begin
              cor_start = 1'b1;
              state_nxt = poi_pkg::ST_COR1;
            end
          end
        end
      end
      poi_pkg::ST_COR1: begin
        if (cor_done) begin
          mx_start  = 1'b1;
          my_start  = 1'b1;
          state_nxt = poi_pkg::ST_MUL1;
        end
      end
      poi_pkg::ST_MUL1: begin
        mx_a  = poi_pkg::rnd15(mx_p);
        my_a  = poi_pkg::rnd15(my_p);
        mx_b  = dt_r;
        my_b  = dt_r;
        m_n   = poi_pkg::MUL_CNT_W'(24);
        m_sgn = 1'b0;
        if (mx_done) begin
          mx_start  = 1'b1;
          my_start  = 1'b1;
          state_nxt = poi_pkg::ST_MUL2;
        end
      end
      poi_pkg::ST_MUL2: begin
        mx_a  = 64'(w_r);
        mx_b  = dt_r;
        m_n   = poi_pkg::MUL_CNT_W'(24);
        m_sgn = 1'b0;
        if (mx_done) begin
          pos_upd   = 1'b1;
          mx_start  = 1'b1;
          state_nxt = poi_pkg::ST_MUL3;
        end
      end
      poi_pkg::ST_MUL3: begin
        mx_a  = mx_p;
        mx_b  = poi_pkg::YAW_SCALE;
        m_n   = poi_pkg::MUL_CNT_W'(24);
        m_sgn = 1'b0;
        if (mx_done) begin
          mx_start  = 1'b1;
          state_nxt = poi_pkg::ST_MUL4;
        end
      end
      poi_pkg::ST_MUL4: begin
        cor_ang = {1'b0, head_nxt[31:1]};
        if (mx_done) begin
          head_upd  = 1'b1;
          cor_start = 1'b1;
          state_nxt = poi_pkg::ST_COR2;
        end
      end
      poi_pkg::ST_COR2: begin
        if (cor_done) begin
          state_nxt = poi_pkg::ST_OUT;
        end
      end
      poi_pkg::ST_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = poi_pkg::ST_IDLE;
        end
      end
      default: state_nxt = poi_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gap_r       <= poi_pkg::GAP_RESET;
      last_r      <= '0;
      posx_r      <= '0;
      posy_r      <= '0;
      head_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        gap_r <= cfg_wdata;
      end
      if (take) begin
        last_r <= in_word.stamp_us;
      end
      if (clr) begin
        posx_r <= '0;
        posy_r <= '0;
        head_r <= '0;
      end
      if (pos_upd) begin
        posx_r <= posx_nxt;
        posy_r <= posy_nxt;
      end
      if (head_upd) begin
        head_r <= head_nxt;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      stamp_r <= in_word.stamp_us;
      v_r     <= in_word.lin_vel;
      w_r     <= in_word.ang_vel;
      dt_r    <= diff[23:0];
    end
    if (out_load) begin
      out_r.x_nm          <= 48'(posx_r);
      out_r.y_nm          <= 48'(posy_r);
      out_r.yaw           <= head_r;
      out_r.quat_z        <= poi_pkg::q15(cor_s);
      out_r.quat_w        <= poi_pkg::q15(cor_c);
      out_r.speed_out     <= v_r;
      out_r.turn_rate_out <= w_r;
      out_r.stamp_out     <= stamp_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_r;

`include "planar_odometry_integrator_top_assert.svh"

  `POI_ASSERT_IMP(a_acc_idle, in_valid && !in_stall, state_r == poi_pkg::ST_IDLE)
  `POI_ASSERT_NXT(a_load_vis, out_load, out_valid)
  `POI_ASSERT_IMP(a_one_upd, pos_upd, !head_upd && !clr)
  `POI_ASSERT_IMP(a_mul_sync, my_done, mx_done)

endmodule

// ===== hdl/poi_smul.sv =====
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
`timescale 1ns / 1ps
module poi_smul (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic signed [63:0]          a,
  input  logic [poi_pkg::MUL_B_W-1:0] b,
  input  logic [poi_pkg::MUL_CNT_W-1:0] nbits,
  input  logic                        b_signed,
  output logic signed [63:0]          prod,
  output logic                        done
);

  logic                          busy_r, done_r, sgn_r;
  logic [poi_pkg::MUL_CNT_W-1:0] cnt_r, nb_r;
  logic signed [63:0]            ar_r, acc_r;
  logic [poi_pkg::MUL_B_W-1:0]   br_r;
  logic                          last;

  assign last = (cnt_r == nb_r - 1'b1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && last) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      ar_r  <= a;
      br_r  <= b;
      nb_r  <= nbits;
      sgn_r <= b_signed;
      cnt_r <= '0;
      acc_r <= '0;
    end else if (busy_r) begin
      // sign bit of a signed multiplier carries negative weight
      if (br_r[0]) begin
        acc_r <= (sgn_r && last) ? acc_r - ar_r : acc_r + ar_r;
      end
      ar_r  <= ar_r <<< 1;
      br_r  <= br_r >> 1;
      cnt_r <= cnt_r + 1'b1;
    end
  end

  assign prod = acc_r;
  assign done = done_r;

endmodule

// ===== hdl/poi_cordic.sv =====
// Iterative rotation-mode CORDIC, one micro-rotation per cycle.
`timescale 1ns / 1ps
module poi_cordic #(
  parameter int STEPS = poi_pkg::CORDIC_STEPS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [31:0]                  ang,
  output logic signed [poi_pkg::CW-1:0] cos_o,
  output logic signed [poi_pkg::CW-1:0] sin_o,
  output logic                         done
);

  localparam int IW = $clog2(STEPS + 1);

  logic                          busy_r, done_r, flip_r;
  logic [IW-1:0]                 cnt_r;
  logic signed [poi_pkg::CW-1:0] x_r, y_r, z_r, dx, dy, at;
  logic                          flip;
  logic [31:0]                   fa;

  always_comb begin
    flip = ang[31] ^ ang[30];
    fa   = flip ? {~ang[31], ang[30:0]} : ang;
    dx   = y_r >>> cnt_r;
    dy   = x_r >>> cnt_r;
    at   = poi_pkg::atan_lut(5'(cnt_r));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == IW'(STEPS - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r    <= poi_pkg::CORDIC_X0;
      y_r    <= '0;
      z_r    <= poi_pkg::CW'($signed(fa));
      flip_r <= flip;
      cnt_r  <= '0;
    end else if (busy_r) begin
      if (!z_r[poi_pkg::CW-1]) begin
        x_r <= x_r - dx;
        y_r <= y_r + dy;
        z_r <= z_r - at;
      end else begin
        x_r <= x_r + dx;
        y_r <= y_r - dy;
        z_r <= z_r + at;
      end
      cnt_r <= cnt_r + 1'b1;
    end
  end

  assign cos_o = flip_r ? -x_r : x_r;
  assign sin_o = flip_r ? -y_r : y_r;
  assign done  = done_r;

endmodule

// ===== tb/planar_odometry_integrator_top_tb.sv =====
// Testbench for the planar odometry integrator: random and directed samples checked against a pose predictor.
`timescale 1ns / 1ps
module planar_odometry_integrator_top_tb;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES = 140;
  localparam longint YAW_K = 64'sd11468322;
  localparam longint POS_MAX = (64'sd1 <<< 47) - 1;
  localparam longint ATAN_Q30 [0:29] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
    41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
    10, 5, 3, 1
  };

  class pose_scoreboard;
    longint px;
    longint py;
    bit [31:0] hdg;
    bit [47:0] prev_stamp;
    bit [23:0] gap;
    poi_pkg::poi_out_t pose_q[$];

    function new();
      px = 0;
      py = 0;
      hdg = 0;
      prev_stamp = 0;
      gap = poi_pkg::GAP_RESET;
    endfunction

    static function longint rnd(longint a, int k);
      return (a + (longint'(1) <<< (k - 1))) >>> k;
    endfunction

    static function void rotate(bit [31:0] ang, output longint c, output longint s);
      bit flip;
      bit [31:0] a;
      longint x, y, z, dx, dy;
      a = ang;
      flip = 0;
      if (((a + 32'h4000_0000) & 32'h8000_0000) != 0) begin
        flip = 1;
        a = a - 32'h8000_0000;
      end
      z = longint'($signed(a));
      x = 652032874;
      y = 0;
      for (int i = 0; i < poi_pkg::CORDIC_STEPS_DEF && i < 30; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (z >= 0) begin
          x = x - dx;
          y = y + dy;
          z = z - ATAN_Q30[i];
        end else begin
          x = x + dx;
          y = y - dy;
          z = z + ATAN_Q30[i];
        end
      end
      c = flip ? -x : x;
      s = flip ? -y : y;
    endfunction

    static function longint sat_add(longint p, longint d);
      longint t;
      t = p + d;
      if (t > POS_MAX) t = POS_MAX;
      if (t < -POS_MAX - 1) t = -POS_MAX - 1;
      return t;
    endfunction

    static function logic signed [15:0] to_q15(longint v);
      longint r;
      r = rnd(v, 15);
      if (r > 32767) r = 32767;
      if (r < -32768) r = -32768;
      return r[15:0];
    endfunction

    function void note_input(poi_pkg::poi_in_t w);
      bit [47:0] diff;
      longint dt, v, wr, c, s, qw, qz, hstep;
      poi_pkg::poi_out_t e;
      if (w.mode) begin
        px = 0;
        py = 0;
        hdg = 0;
        return;
      end
      diff = w.stamp_us - prev_stamp;
      prev_stamp = w.stamp_us;
      if (diff == 0 || diff[47] || diff > gap) return;
      dt = longint'(diff);
      v = w.lin_vel;
      wr = w.ang_vel;
      rotate(hdg, c, s);
      px = sat_add(px, rnd(rnd(v * c, 15) * dt, 15));
      py = sat_add(py, rnd(rnd(v * s, 15) * dt, 15));
      hstep = rnd(wr * dt * YAW_K, 24);
      hdg = hdg + hstep[31:0];
      rotate(hdg >> 1, qw, qz);
      e.x_nm = px[47:0];
      e.y_nm = py[47:0];
      e.yaw = hdg;
      e.quat_z = to_q15(qz);
      e.quat_w = to_q15(qw);
      e.speed_out = w.lin_vel;
      e.turn_rate_out = w.ang_vel;
      e.stamp_out = w.stamp_us;
      pose_q.push_back(e);
    endfunction

    function string check_result(poi_pkg::poi_out_t got);
      poi_pkg::poi_out_t e;
      string s;
      if (pose_q.size() == 0) return "result word with no pose expected";
      e = pose_q.pop_front();
      s = "";
      if (got.x_nm !== e.x_nm) s = {s, $sformatf(" x_nm %0d/%0d", got.x_nm, e.x_nm)};
      if (got.y_nm !== e.y_nm) s = {s, $sformatf(" y_nm %0d/%0d", got.y_nm, e.y_nm)};
      if (got.yaw !== e.yaw) s = {s, $sformatf(" yaw %h/%h", got.yaw, e.yaw)};
      if (got.quat_z !== e.quat_z) s = {s, $sformatf(" quat_z %0d/%0d", got.quat_z, e.quat_z)};
      if (got.quat_w !== e.quat_w) s = {s, $sformatf(" quat_w %0d/%0d", got.quat_w, e.quat_w)};
      if (got.speed_out !== e.speed_out)
        s = {s, $sformatf(" speed_out %0d/%0d", got.speed_out, e.speed_out)};
      if (got.turn_rate_out !== e.turn_rate_out)
        s = {s, $sformatf(" turn_rate_out %0d/%0d", got.turn_rate_out, e.turn_rate_out)};
      if (got.stamp_out !== e.stamp_out)
        s = {s, $sformatf(" stamp_out %h/%h", got.stamp_out, e.stamp_out)};
      return s;
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid;
  logic in_stall;
  poi_pkg::poi_in_t in_word;
  logic out_valid;
  logic out_stall;
  poi_pkg::poi_out_t out_word;
  logic cfg_we;
  logic [23:0] cfg_wdata;

  pose_scoreboard sb = new();
  int errors = 0;
  int quiet_cycles = 0;
  bit bursts_on = 1;
  int stall_left = 0;
  bit [47:0] tb_stamp = 0;

  planar_odometry_integrator_top DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
    .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  task automatic report(string msg);
    errors++;
    $display("%0t mismatch:%s", $realtime, msg);
  endtask

  always @(posedge clk) begin
    string s;
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note_input(in_word);
      if (out_valid && !out_stall) begin
        s = sb.check_result(out_word);
        if (s != "") report(s);
      end
    end
  end

  always @(posedge clk) begin
    logic nxt;
    nxt = 0;
    if (stall_left > 0) begin
      stall_left--;
      nxt = 1;
    end else if (bursts_on && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(0, 18);
      nxt = 1;
    end
    out_stall <= nxt;
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  task automatic send(poi_pkg::poi_in_t w);
    if (bursts_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_valid <= 1;
    in_word <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (sb.pose_q.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_gap(logic [23:0] g);
    drain();
    cfg_we <= 1;
    cfg_wdata <= g;
    @(posedge clk);
    cfg_we <= 0;
    sb.gap = g;
  endtask

  task automatic sample(longint dt, logic signed [15:0] v, logic signed [15:0] w);
    poi_pkg::poi_in_t x;
    tb_stamp = tb_stamp + dt[47:0];
    x.mode = 1'b0;
    x.stamp_us = tb_stamp;
    x.lin_vel = v;
    x.ang_vel = w;
    send(x);
  endtask

  task automatic stamp_jump(bit [47:0] st);
    poi_pkg::poi_in_t x;
    tb_stamp = st;
    x.mode = 1'b0;
    x.stamp_us = st;
    x.lin_vel = 16'($urandom);
    x.ang_vel = 16'($urandom);
    send(x);
  endtask

  task automatic clear_pose();
    poi_pkg::poi_in_t x;
    x.mode = 1'b1;
    x.stamp_us = 48'({$urandom, $urandom});
    x.lin_vel = 16'($urandom);
    x.ang_vel = 16'($urandom);
    send(x);
  endtask

  function automatic logic signed [15:0] rand_vel();
    case ($urandom_range(0, 9))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return 16'sh0000;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic random_items(int n, longint g);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 5) clear_pose();
      else if (r < 10) stamp_jump(48'({$urandom, $urandom}));
      else if (r < 14) sample(0, rand_vel(), rand_vel());
      else if (r < 18) sample(-longint'($urandom_range(1, 5000)), rand_vel(), rand_vel());
      else if (r < 23) sample(g + $urandom_range(1, 1000), rand_vel(), rand_vel());
      else if (r < 35) sample(g == 0 ? 1 : g, rand_vel(), rand_vel());
      else sample(g == 0 ? 1 : $urandom_range(1, 32'(g)), rand_vel(), rand_vel());
    end
  endtask

  initial begin
    in_valid <= 0;
    in_word <= '0;
    out_stall <= 0;
    cfg_we <= 0;
    cfg_wdata <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: extremes, drops, clear, stamp wrap
    sample(1, 16'sh7fff, 16'sh7fff);
    sample(1000000, 16'sh8000, 16'sh8000);
    sample(1000001, 16'sh1234, 16'sh0100);
    sample(0, 16'sh0100, 16'sh0100);
    sample(-5, 16'sh0100, 16'sh0100);
    sample(500, 16'sh0000, 16'sh0000);
    clear_pose();
    sample(1000, 16'sh03e8, 16'sh0000);
    sample(1000000, 16'sh03e8, 16'sh7fff);
    sample(1000000, 16'sh7fff, 16'sh4000);
    sample(700000, 16'shc000, 16'sh8000);
    stamp_jump(48'hffff_ffff_fff0);
    sample(32, 16'sh0555, 16'shfaaa);
    stamp_jump(48'haaaa_aaaa_aaaa);
    stamp_jump(48'h5555_5555_5555);
    sample(10, 16'sh7fff, 16'sh0001);

    // long runs at the largest step drive both axes into saturation
    set_gap(24'hffffff);
    clear_pose();
    for (int i = 0; i < 270; i++) sample(24'hffffff, 16'sh7fff, 16'sh0000);
    clear_pose();
    sample(1000000, 16'sh0000, -16'sd1571);
    for (int i = 0; i < 270; i++) sample(24'hffffff, 16'sh8000, 16'sh0000);

    set_gap(24'd1);
    random_items(120, 1);
    set_gap(24'd0);
    random_items(20, 0);
    set_gap(24'd1000000);
    random_items(150, 1000000);
    set_gap(24'(1 + $urandom_range(0, 24'hfffffe)));
    random_items(150, sb.gap);
    set_gap(24'hffffff);
    bursts_on = 0;
    random_items(150, 24'hffffff);

    drain();
    repeat (60) @(posedge clk);
    if (errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end
endmodule
